// ----- sv/haptic_pattern_sequencer_defines.svh -----
// assertion macros for the haptic pattern sequencer
// included by files that carry concurrent assertions, needs nothing else
`ifndef HAPTIC_PATTERN_SEQUENCER_DEFINES_SVH
`define HAPTIC_PATTERN_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF
// property checked on every clock edge outside reset
`define HPS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("hps assertion failed");
// consequent must hold in the cycle after the antecedent
`define HPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hps assertion failed");
`else
`define HPS_ASSERT(lbl, clk, rst_n, prop)
`define HPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/hps_pkg.sv -----
// shared types, codes and constants of the haptic pattern sequencer
// used by hps_serial_mul and haptic_pattern_sequencer, depends on nothing
`default_nettype none

package hps_pkg;

    // field widths
    localparam int OP_W       = 2;
    localparam int PAT_W      = 3;
    localparam int STRENGTH_W = 9;
    localparam int INTENS_W   = 10;
    localparam int DUTY_W     = 8;
    localparam int PHASE_W    = 2;
    localparam int MS_W       = 6;
    localparam int LEVEL_W    = 9;

    // serial multiplier: multiplicand a, multiplier b taken one bit per cycle
    localparam int MUL_A_W   = 10;
    localparam int MUL_B_W   = 9;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = 4;
    localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MUL_B_W - 1);

    // op codes
    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_TRIGGER = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP    = 2'd2;

    // pattern codes
    localparam logic [PAT_W-1:0] PAT_NONE   = 3'd0;
    localparam logic [PAT_W-1:0] PAT_CLICK  = 3'd1;
    localparam logic [PAT_W-1:0] PAT_TICK   = 3'd2;
    localparam logic [PAT_W-1:0] PAT_THUD   = 3'd3;
    localparam logic [PAT_W-1:0] PAT_DOUBLE = 3'd4;

    // phases
    localparam logic [PHASE_W-1:0] PH_FIRST  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_SECOND = 2'd1;
    localparam logic [PHASE_W-1:0] PH_THIRD  = 2'd2;

    // phase lengths in ms
    localparam logic [MS_W-1:0] MS_CLICK_ON  = 6'd25;
    localparam logic [MS_W-1:0] MS_CLICK_OFF = 6'd15;
    localparam logic [MS_W-1:0] MS_TICK_ON   = 6'd12;
    localparam logic [MS_W-1:0] MS_THUD_ON   = 6'd60;
    localparam logic [MS_W-1:0] MS_DBL_ON    = 6'd15;
    localparam logic [MS_W-1:0] MS_DBL_OFF   = 6'd25;
    localparam logic [MS_W-1:0] MS_MAX       = 6'd63;

    // q8 level limits
    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 9'd256;
    localparam logic [LEVEL_W-1:0] LEVEL_MIN = 9'd13;

    // register map
    localparam logic REG_INTENSITY = 1'b0;
    localparam logic REG_ENABLE    = 1'b1;
    localparam logic [INTENS_W-1:0] INTENS_RESET = 10'd256;

    // status of the serial multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

    function automatic logic [DUTY_W-1:0] base_duty(input logic [PAT_W-1:0] pat);
        logic [DUTY_W-1:0] b;
        case (pat)
            PAT_CLICK:  b = 8'd160;
            PAT_TICK:   b = 8'd80;
            PAT_THUD:   b = 8'd220;
            PAT_DOUBLE: b = 8'd140;
            default:    b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- sv/haptic_pattern_sequencer.sv -----
// Haptic pattern sequencer: one result beat per input beat. An accepted beat goes to
// EXEC; tick, stop, unused op codes and triggers failing the enable or pattern check
// then go to OUT. A passing trigger makes two passes through the shared bit-serial
// multiplier in MUL1 and MUL2 (each a load and nine shift-add steps: strength times
// intensity, then base duty times level), the second skipped for too weak a level.
// Input and output are decoupled by an output register, so the next beat is taken
// while a result waits. The user must write registers (intensity at 0x0, enable at
// 0x4) over the APB port only while no beat is in flight; the block does not enforce
// this. Depends on hps_pkg, hps_serial_mul and haptic_pattern_sequencer_defines.svh.
`default_nettype none

`include "haptic_pattern_sequencer_defines.svh"

module haptic_pattern_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [2:0] pattern, [11:3] strength, rest zero
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] op
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,   // [7:0] motor_duty, [8] duty_written,
                                             // [9] busy_res, rest zero
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_MUL1 = 5'b00100,
        ST_MUL2 = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // registers
    logic [hps_pkg::INTENS_W-1:0]   r_intensity;
    logic                           r_enable;

    // latched item
    logic [hps_pkg::OP_W-1:0]       r_op, n_op;
    logic [hps_pkg::PAT_W-1:0]      r_pat, n_pat;
    logic [hps_pkg::STRENGTH_W-1:0] r_strength, n_strength;

    // pattern state
    logic [hps_pkg::PAT_W-1:0]      r_active, n_active;
    logic [hps_pkg::DUTY_W-1:0]     r_pduty, n_pduty;
    logic [hps_pkg::PHASE_W-1:0]    r_phase, n_phase;
    logic [hps_pkg::MS_W-1:0]       r_phase_ms, n_phase_ms;
    logic [hps_pkg::DUTY_W-1:0]     r_drive, n_drive;
    logic                           r_wrote, n_wrote;

    // output register
    logic                           r_out_valid, n_out_valid;
    logic [hps_pkg::DUTY_W-1:0]     r_out_duty, n_out_duty;
    logic                           r_out_written, n_out_written;
    logic                           r_out_busy, n_out_busy;

    // multiplier
    logic                           mul_start;
    logic [hps_pkg::MUL_A_W-1:0]    mul_a;
    logic [hps_pkg::MUL_B_W-1:0]    mul_b;
    hps_pkg::t_mul_stat             mul_stat;
    logic [hps_pkg::MUL_P_W-1:0]    mul_prod;

    logic [hps_pkg::MUL_P_W-9:0]    lvl_raw;
    logic [hps_pkg::LEVEL_W-1:0]    level;
    logic [hps_pkg::MS_W-1:0]       ms_inc;
    logic                           do_write;
    logic [hps_pkg::DUTY_W-1:0]     write_val;
    logic                           cfg_wr;
    logic                           reg_idx;

    hps_serial_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_stat    (mul_stat),
        .o_product (mul_prod)
    );

    // register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel & penable & pwrite;

    always_comb begin
        case (reg_idx)
            hps_pkg::REG_INTENSITY: prdata = {22'd0, r_intensity};
            hps_pkg::REG_ENABLE:    prdata = {31'd0, r_enable};
            default:                prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_intensity <= hps_pkg::INTENS_RESET;
            r_enable    <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_idx)
                hps_pkg::REG_INTENSITY: r_intensity <= pwdata[hps_pkg::INTENS_W-1:0];
                hps_pkg::REG_ENABLE:    r_enable    <= pwdata[0];
                default:                ;
            endcase
        end
    end

    // level = (strength * intensity) >> 8, clamped to 1.0
    assign lvl_raw = mul_prod[hps_pkg::MUL_P_W-1:8];
    assign level   = (lvl_raw > 11'(hps_pkg::LEVEL_ONE)) ? hps_pkg::LEVEL_ONE
                                                         : lvl_raw[hps_pkg::LEVEL_W-1:0];
    assign ms_inc  = (r_phase_ms < hps_pkg::MS_MAX) ? r_phase_ms + 6'd1 : r_phase_ms;

    assign s_axis_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_pat         = r_pat;
        n_strength    = r_strength;
        n_active      = r_active;
        n_pduty       = r_pduty;
        n_phase       = r_phase;
        n_phase_ms    = r_phase_ms;
        n_drive       = r_drive;
        n_wrote       = r_wrote;
        n_out_valid   = r_out_valid;
        n_out_duty    = r_out_duty;
        n_out_written = r_out_written;
        n_out_busy    = r_out_busy;
        mul_start     = 1'b0;
        mul_a         = r_intensity;
        mul_b         = r_strength;
        do_write      = 1'b0;
        write_val     = '0;

        if (r_out_valid && m_axis_tready)
            n_out_valid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op       = s_axis_tuser;
                    n_pat      = s_axis_tdata[2:0];
                    n_strength = s_axis_tdata[11:3];
                    n_wrote    = 1'b0;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_OUT;
                case (r_op)
                    hps_pkg::OP_TICK: begin
                        if (r_active != hps_pkg::PAT_NONE) begin
                            n_phase_ms = ms_inc;
                            case (r_active)
                                hps_pkg::PAT_CLICK: begin
                                    if (r_phase == hps_pkg::PH_FIRST
                                        && ms_inc >= hps_pkg::MS_CLICK_ON) begin
                                        do_write   = 1'b1;
                                        n_phase    = hps_pkg::PH_SECOND;
                                        n_phase_ms = '0;
                                    end else if (r_phase == hps_pkg::PH_SECOND
                                                 && ms_inc >= hps_pkg::MS_CLICK_OFF) begin
                                        n_active   = hps_pkg::PAT_NONE;
                                        n_phase    = hps_pkg::PH_FIRST;
                                        n_phase_ms = '0;
                                    end
                                end
                                hps_pkg::PAT_TICK: begin
                                    if (ms_inc >= hps_pkg::MS_TICK_ON) begin
                                        do_write   = 1'b1;
                                        n_active   = hps_pkg::PAT_NONE;
                                        n_phase    = hps_pkg::PH_FIRST;
                                        n_phase_ms = '0;
                                    end
                                end
                                hps_pkg::PAT_THUD: begin
                                    if (ms_inc >= hps_pkg::MS_THUD_ON) begin
                                        do_write   = 1'b1;
                                        n_active   = hps_pkg::PAT_NONE;
                                        n_phase    = hps_pkg::PH_FIRST;
                                        n_phase_ms = '0;
                                    end
                                end
                                hps_pkg::PAT_DOUBLE: begin
                                    if (r_phase == hps_pkg::PH_FIRST
                                        && ms_inc >= hps_pkg::MS_DBL_ON) begin
                                        do_write   = 1'b1;
                                        n_phase    = hps_pkg::PH_SECOND;
                                        n_phase_ms = '0;
                                    end else if (r_phase == hps_pkg::PH_SECOND
                                                 && ms_inc >= hps_pkg::MS_DBL_OFF) begin
                                        do_write   = 1'b1;
                                        write_val  = r_pduty;
                                        n_phase    = hps_pkg::PH_THIRD;
                                        n_phase_ms = '0;
                                    end else if (r_phase == hps_pkg::PH_THIRD
                                                 && ms_inc >= hps_pkg::MS_DBL_ON) begin
                                        do_write   = 1'b1;
                                        n_active   = hps_pkg::PAT_NONE;
                                        n_phase    = hps_pkg::PH_FIRST;
                                        n_phase_ms = '0;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    hps_pkg::OP_TRIGGER: begin
                        if (r_enable && (r_pat inside {hps_pkg::PAT_CLICK, hps_pkg::PAT_TICK,
                                                       hps_pkg::PAT_THUD,
                                                       hps_pkg::PAT_DOUBLE})) begin
                            mul_start = 1'b1;
                            n_state   = ST_MUL1;
                        end
                    end
                    hps_pkg::OP_STOP: begin
                        do_write   = 1'b1;
                        n_active   = hps_pkg::PAT_NONE;
                        n_phase    = hps_pkg::PH_FIRST;
                        n_phase_ms = '0;
                    end
                    default: ;
                endcase
            end
            ST_MUL1: begin
                if (mul_stat.done) begin
                    if (level < hps_pkg::LEVEL_MIN) begin
                        // weak trigger, nothing changes
                        n_state = ST_OUT;
                    end else begin
                        mul_start = 1'b1;
                        mul_a     = {2'b00, hps_pkg::base_duty(r_pat)};
                        mul_b     = level;
                        n_state   = ST_MUL2;
                    end
                end
            end
            ST_MUL2: begin
                if (mul_stat.done) begin
                    n_active   = r_pat;
                    n_pduty    = mul_prod[15:8];
                    n_phase    = hps_pkg::PH_FIRST;
                    n_phase_ms = '0;
                    do_write   = 1'b1;
                    write_val  = mul_prod[15:8];
                    n_state    = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid   = 1'b1;
                    n_out_duty    = r_drive;
                    n_out_written = r_wrote;
                    n_out_busy    = (r_active != hps_pkg::PAT_NONE);
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // duty writes reach the motor only when enabled
        if (do_write && r_enable) begin
            n_drive = write_val;
            n_wrote = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= hps_pkg::PAT_NONE;
            r_pduty     <= '0;
            r_phase     <= hps_pkg::PH_FIRST;
            r_phase_ms  <= '0;
            r_drive     <= '0;
            r_wrote     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_pduty     <= n_pduty;
            r_phase     <= n_phase;
            r_phase_ms  <= n_phase_ms;
            r_drive     <= n_drive;
            r_wrote     <= n_wrote;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_pat         <= n_pat;
        r_strength    <= n_strength;
        r_out_duty    <= n_out_duty;
        r_out_written <= n_out_written;
        r_out_busy    <= n_out_busy;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_busy, r_out_written, r_out_duty};

    // no pattern running means the phase timer is parked
    `HPS_ASSERT(a_idle_parked, i_clk, i_rst_n,
        (r_active != hps_pkg::PAT_NONE) || (r_phase == hps_pkg::PH_FIRST && r_phase_ms == 6'd0))
    // multiplier results arrive only while the sequencer waits for them
    `HPS_ASSERT(a_mul_done_expected, i_clk, i_rst_n,
        !mul_stat.done || r_state == ST_MUL1 || r_state == ST_MUL2)
    // a finished item with a free output register is shown next cycle
    `HPS_ASSERT_NEXT(a_out_loaded, i_clk, i_rst_n,
        r_state == ST_OUT && !r_out_valid, r_out_valid && r_state == ST_IDLE)

endmodule

`default_nettype wire

// ----- sv/hps_serial_mul.sv -----
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on hps_pkg
`default_nettype none

module hps_serial_mul (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [hps_pkg::MUL_A_W-1:0]   i_a,
    input  wire logic [hps_pkg::MUL_B_W-1:0]   i_b,
    output hps_pkg::t_mul_stat                 o_stat,
    output logic      [hps_pkg::MUL_P_W-1:0]   o_product
);

    logic [hps_pkg::MUL_P_W-1:0]   r_acc, n_acc;
    logic [hps_pkg::MUL_A_W-1:0]   r_a, n_a;
    logic [hps_pkg::MUL_CNT_W-1:0] r_cnt, n_cnt;
    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [hps_pkg::MUL_A_W:0]     sum;

    // upper half accumulates, lower half shifts out the multiplier bits
    assign sum = {1'b0, r_acc[hps_pkg::MUL_P_W-1:hps_pkg::MUL_B_W]}
               + (r_acc[0] ? {1'b0, r_a} : '0);

    always_comb begin
        n_acc  = r_acc;
        n_a    = r_a;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_acc  = {{hps_pkg::MUL_A_W{1'b0}}, i_b};
            n_a    = i_a;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_acc = {sum, r_acc[hps_pkg::MUL_B_W-1:1]};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == hps_pkg::MUL_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_a   <= n_a;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_product   = r_acc;

endmodule

`default_nettype wire

// ----- sim/haptic_pattern_sequencer_tb.sv -----
// testbench for haptic_pattern_sequencer: directed and random beats against a duty predictor
// depends on hps_pkg and the haptic_pattern_sequencer rtl, drives both streams and the apb port
`timescale 1ns / 1ps

module haptic_pattern_sequencer_tb;

    localparam logic [2:0] ADDR_INTENS = {hps_pkg::REG_INTENSITY, 2'b00};
    localparam logic [2:0] ADDR_EN     = {hps_pkg::REG_ENABLE, 2'b00};

    typedef struct packed {
        logic [7:0] duty;
        logic       written;
        logic       busy;
    } t_duty_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_data = '0;   // [2:0] pattern, [11:3] strength, rest zero
    logic [1:0]  s_user = '0;   // [1:0] op
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_data;        // [7:0] motor_duty, [8] duty_written, [9] busy_res, rest zero
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of registers and sequencer state
    logic [9:0]  cfg_intens = hps_pkg::INTENS_RESET;
    logic        cfg_en = 1'b0;
    logic [2:0]  cur_pat = hps_pkg::PAT_NONE;
    logic [7:0]  cur_duty = '0;
    logic [1:0]  cur_ph = hps_pkg::PH_FIRST;
    logic [5:0]  cur_ms = '0;
    logic [7:0]  motor = '0;
    logic        wrote_now;

    t_duty_beat duty_q[$];
    int mismatches = 0;
    int beats_in = 0;
    int hold_left = 0;
    bit no_idle = 1'b0;

    haptic_pattern_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1ms;
        $display("haptic_pattern_sequencer_tb: FAIL");
        $finish;
    end

    function automatic void drive_motor(input logic [7:0] d);
        if (cfg_en) begin
            motor = d;
            wrote_now = 1'b1;
        end
    endfunction

    function automatic void end_pattern();
        cur_pat = hps_pkg::PAT_NONE;
        cur_ph = hps_pkg::PH_FIRST;
        cur_ms = '0;
    endfunction

    function automatic void enter_phase(input logic [1:0] p);
        cur_ph = p;
        cur_ms = '0;
    endfunction

    // advances the predicted sequencer by one beat, returns the expected result
    function automatic t_duty_beat step_pattern(input logic [1:0] op, input logic [2:0] pat,
                                                input logic [8:0] str);
        logic [7:0]  base;
        logic [18:0] prod;
        logic [10:0] lvl;
        logic [16:0] dprod;
        t_duty_beat  r;
        wrote_now = 1'b0;
        case (op)
            hps_pkg::OP_TICK: begin
                if (cur_pat != hps_pkg::PAT_NONE) begin
                    if (cur_ms < 6'd63) cur_ms = cur_ms + 6'd1;
                    case (cur_pat)
                        hps_pkg::PAT_CLICK: begin
                            if (cur_ph == hps_pkg::PH_FIRST && cur_ms >= 6'd25) begin
                                drive_motor(8'd0);
                                enter_phase(hps_pkg::PH_SECOND);
                            end else if (cur_ph == hps_pkg::PH_SECOND && cur_ms >= 6'd15) begin
                                end_pattern();
                            end
                        end
                        hps_pkg::PAT_TICK: begin
                            if (cur_ms >= 6'd12) begin
                                drive_motor(8'd0);
                                end_pattern();
                            end
                        end
                        hps_pkg::PAT_THUD: begin
                            if (cur_ms >= 6'd60) begin
                                drive_motor(8'd0);
                                end_pattern();
                            end
                        end
                        hps_pkg::PAT_DOUBLE: begin
                            if (cur_ph == hps_pkg::PH_FIRST && cur_ms >= 6'd15) begin
                                drive_motor(8'd0);
                                enter_phase(hps_pkg::PH_SECOND);
                            end else if (cur_ph == hps_pkg::PH_SECOND && cur_ms >= 6'd25) begin
                                drive_motor(cur_duty);
                                enter_phase(hps_pkg::PH_THIRD);
                            end else if (cur_ph == hps_pkg::PH_THIRD && cur_ms >= 6'd15) begin
                                drive_motor(8'd0);
                                end_pattern();
                            end
                        end
                        default: ;
                    endcase
                end
            end
            hps_pkg::OP_TRIGGER: begin
                case (pat)
                    hps_pkg::PAT_CLICK:  base = 8'd160;
                    hps_pkg::PAT_TICK:   base = 8'd80;
                    hps_pkg::PAT_THUD:   base = 8'd220;
                    hps_pkg::PAT_DOUBLE: base = 8'd140;
                    default:             base = 8'd0;
                endcase
                prod = 19'(str) * 19'(cfg_intens);
                lvl = prod[18:8];
                if (lvl > 11'd256) lvl = 11'd256;
                // disabled, unknown pattern or weak level leaves everything as it was
                if (cfg_en && base != 8'd0 && lvl >= 11'd13) begin
                    dprod = 17'(base) * 17'(lvl);
                    cur_pat = pat;
                    cur_duty = dprod[15:8];
                    enter_phase(hps_pkg::PH_FIRST);
                    drive_motor(cur_duty);
                end
            end
            hps_pkg::OP_STOP: begin
                drive_motor(8'd0);
                end_pattern();
            end
            default: ;
        endcase
        r.duty = motor;
        r.written = wrote_now;
        r.busy = (cur_pat != hps_pkg::PAT_NONE);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic send_beat(input logic [1:0] op, input logic [2:0] pat, input logic [8:0] str);
        while (!no_idle && $urandom_range(0, 99) < 25) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user <= op;
        s_data <= {4'b0, str, pat};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        duty_q.push_back(step_pattern(op, pat, str));
        beats_in++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (duty_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_INTENS) cfg_intens = val[9:0];
        else cfg_en = val[0];
        @(posedge i_clk);
    endtask

    // mostly a trigger followed by a run of ticks with rare stops, the rest random noise beats
    task automatic run_sequences(input int n_beats);
        int start;
        int n_ticks;
        logic [8:0] str;
        start = beats_in;
        while (beats_in - start < n_beats) begin
            if ($urandom_range(0, 99) < 75) begin
                str = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                                  : 9'($urandom_range(0, 256));
                send_beat(hps_pkg::OP_TRIGGER, 3'($urandom_range(1, 4)), str);
                n_ticks = $urandom_range(0, 72);
                repeat (n_ticks) begin
                    if ($urandom_range(0, 199) == 0)
                        send_beat(hps_pkg::OP_STOP, 3'($urandom), 9'($urandom));
                    else
                        send_beat(hps_pkg::OP_TICK, 3'($urandom), 9'($urandom));
                end
            end else begin
                repeat ($urandom_range(1, 4))
                    send_beat(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                              9'($urandom_range(0, 511)));
            end
        end
        wait_idle();
    endtask

    task automatic test_directed_codes();
        // still at reset settings: disabled block ignores everything
        send_beat(hps_pkg::OP_TRIGGER, hps_pkg::PAT_CLICK, 9'd256);
        send_beat(hps_pkg::OP_TICK, hps_pkg::PAT_NONE, 9'd0);
        send_beat(hps_pkg::OP_STOP, hps_pkg::PAT_NONE, 9'd0);
        wait_idle();
        reg_write(ADDR_EN, 32'd1);
        reg_write(ADDR_INTENS, 32'd256);
        send_beat(2'd3, 3'd7, 9'd511);
        send_beat(hps_pkg::OP_TICK, hps_pkg::PAT_NONE, 9'd0);
        send_beat(hps_pkg::OP_TRIGGER, hps_pkg::PAT_NONE, 9'd256);
        send_beat(hps_pkg::OP_TRIGGER, 3'd5, 9'd256);
        send_beat(hps_pkg::OP_TRIGGER, hps_pkg::PAT_CLICK, 9'd12);
        send_beat(hps_pkg::OP_TRIGGER, hps_pkg::PAT_CLICK, 9'd13);
        send_beat(hps_pkg::OP_TRIGGER, hps_pkg::PAT_THUD, 9'd511);
        send_beat(hps_pkg::OP_TRIGGER, hps_pkg::PAT_TICK, 9'd256);
        send_beat(hps_pkg::OP_STOP, hps_pkg::PAT_NONE, 9'd0);
        send_beat(hps_pkg::OP_TRIGGER, hps_pkg::PAT_DOUBLE, 9'd256);
        wait_idle();
        // disable mid pattern: state moves on, motor holds its duty
        reg_write(ADDR_EN, 32'd0);
        repeat (3) send_beat(hps_pkg::OP_TICK, hps_pkg::PAT_NONE, 9'd0);
        send_beat(hps_pkg::OP_TRIGGER, hps_pkg::PAT_CLICK, 9'd256);
        send_beat(hps_pkg::OP_STOP, hps_pkg::PAT_NONE, 9'd0);
        wait_idle();
        reg_write(ADDR_EN, 32'd1);
    endtask

    task automatic test_nominal();
        reg_write(ADDR_INTENS, 32'd256);
        run_sequences(300);
    endtask

    task automatic test_full_scale();
        reg_write(ADDR_INTENS, 32'd1023);
        run_sequences(200);
    endtask

    task automatic test_random_intensity();
        repeat (3) begin
            reg_write(ADDR_INTENS, $urandom_range(0, 1023));
            run_sequences(80);
        end
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        reg_write(ADDR_INTENS, $urandom_range(0, 1023));
        run_sequences(200);
        no_idle = 1'b0;
    endtask

    task automatic test_weak_levels();
        reg_write(ADDR_INTENS, 32'd0);
        run_sequences(50);
        repeat (2) begin
            reg_write(ADDR_INTENS, $urandom_range(10, 80));
            run_sequences(80);
        end
    endtask

    task automatic test_disabled_run();
        reg_write(ADDR_INTENS, 32'd256);
        send_beat(hps_pkg::OP_TRIGGER, 3'($urandom_range(1, 4)), 9'd256);
        wait_idle();
        reg_write(ADDR_EN, 32'd0);
        run_sequences(60);
        reg_write(ADDR_EN, 32'd1);
    endtask

    task automatic test_output_stall();
        reg_write(ADDR_INTENS, 32'd256);
        hold_left = 400;
        run_sequences(40);
    endtask

    // result side: checks each accepted beat and sets tready for the next edge
    initial begin : result_monitor
        t_duty_beat want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_valid && m_ready) begin
                if (duty_q.size() == 0) begin
                    report_mismatch("result beat with nothing pending", 0, 0);
                end else begin
                    want = duty_q.pop_front();
                    if (m_data[7:0] != want.duty)
                        report_mismatch("motor_duty", m_data[7:0], want.duty);
                    if (m_data[8] != want.written)
                        report_mismatch("duty_written", m_data[8], want.written);
                    if (m_data[9] != want.busy)
                        report_mismatch("busy_res", m_data[9], want.busy);
                end
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= no_idle || ($urandom_range(0, 99) >= 25);
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_codes();
        test_nominal();
        test_full_scale();
        test_random_intensity();
        test_back_to_back();
        test_weak_levels();
        test_disabled_run();
        test_output_stall();
        wait_idle();
        if (mismatches == 0)
            $display("haptic_pattern_sequencer_tb: PASS");
        else
            $display("haptic_pattern_sequencer_tb: FAIL");
        $finish;
    end

endmodule

// ----- haptic_pattern_sequencer.f -----
+incdir+sv
sv/hps_pkg.sv
sv/hps_serial_mul.sv
sv/haptic_pattern_sequencer.sv
sim/haptic_pattern_sequencer_tb.sv
